/* hw/rtl/svct_pkg.sv */
// Shared types, constants and a helper function for the saturation/value color threshold.
package svct_pkg;

   localparam int unsigned CHAN_W = 8;
   localparam int unsigned NUM_W  = 2 * CHAN_W;
   localparam int unsigned CSR_IDX_W = 2;

   // Divider layout: two quotient bits are resolved per pipeline stage.
   localparam int unsigned DIV_BITS_PER_STAGE = 2;
   localparam int unsigned DIV_STAGES = CHAN_W / DIV_BITS_PER_STAGE;

   localparam logic [CHAN_W-1:0] SAT_LOW_RESET  = 8'd100;
   localparam logic [CHAN_W-1:0] SAT_HIGH_RESET = 8'd255;
   localparam logic [CHAN_W-1:0] VAL_LOW_RESET  = 8'd50;
   localparam logic [CHAN_W-1:0] VAL_HIGH_RESET = 8'd255;
   localparam logic [CHAN_W-1:0] CHAN_MAX       = 8'd255;

   // Configuration register indexes.
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SAT_LOW  = 2'd0,
      CSR_SAT_HIGH = 2'd1,
      CSR_VAL_LOW  = 2'd2,
      CSR_VAL_HIGH = 2'd3
   } csr_index_type;

   // Payload of one item while it travels through the divider stages.
   typedef struct packed {
      logic              grey;
      logic [CHAN_W-1:0] mx;
      logic [CHAN_W-1:0] den;
      logic [NUM_W-1:0]  rem;
      logic [CHAN_W-1:0] quo;
   } div_stage_type;

   // Resolves two quotient bits, starting at bit position k_hi, by restoring division.
   function automatic div_stage_type div_two(div_stage_type s, int unsigned k_hi);
      div_stage_type    r;
      logic [NUM_W-1:0] shifted;
      r = s;
      for (int unsigned j = 0; j < DIV_BITS_PER_STAGE; j++) begin
         shifted = NUM_W'(r.den) << (k_hi - j);
         if (r.rem >= shifted) begin
            r.rem = r.rem - shifted;
            r.quo[k_hi - j] = 1'b1;
         end
      end
      return r;
   endfunction

endpackage

/* hw/rtl/svct_if.sv */
// Channel interfaces for pixel items, result items and configuration writes.
interface svct_req_if;
   import svct_pkg::*;
   logic              valid;
   logic              ready;
   logic [CHAN_W-1:0] chan_first;
   logic [CHAN_W-1:0] chan_second;
   logic [CHAN_W-1:0] chan_third;
   modport source (output valid, chan_first, chan_second, chan_third, input ready);
   modport sink   (input valid, chan_first, chan_second, chan_third, output ready);
endinterface

interface svct_rsp_if;
   import svct_pkg::*;
   logic              valid;
   logic              ready;
   logic              lane_bit;
   logic [CHAN_W-1:0] saturation;
   logic [CHAN_W-1:0] brightness;
   modport source (output valid, lane_bit, saturation, brightness, input ready);
   modport sink   (input valid, lane_bit, saturation, brightness, output ready);
endinterface

interface svct_csr_if;
   import svct_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [CHAN_W-1:0]    data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

/* hw/rtl/saturation_value_color_threshold.sv */
// Top level of the HLS saturation / HSV value color threshold pipeline.
//
//  Channel   Direction  Handshake      Payload
//  req_chan  in         valid/ready    chan_first, chan_second, chan_third
//  rsp_chan  out        valid/ready    lane_bit, saturation, brightness
//  csr_chan  in         valid/ready    index, data (always ready)
//
// One item enters per cycle while no stall on rsp_chan holds the pipeline.
// The depth is set by min/max, numerator, four two-bit divider stages and round/compare.
// Reset is synchronous; it clears all valid bits and loads the threshold registers with their reset values.
// A stall on rsp_chan freezes the whole pipeline, so req_chan.ready follows it.
module saturation_value_color_threshold
   import svct_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   svct_req_if.sink   req_chan,
   svct_rsp_if.source rsp_chan,
   svct_csr_if.sink   csr_chan
);

   logic [CHAN_W-1:0] sat_low_ff, sat_high_ff, val_low_ff, val_high_ff;

   logic              s1_valid_ff;
   logic [CHAN_W-1:0] s1_mx_ff, s1_mn_ff;
   logic [CHAN_W-1:0] s1_mx_in, s1_mn_in;

   logic              s2_valid_ff;
   div_stage_type     s2_ff, s2_in;

   logic [DIV_STAGES-1:0] dv_valid_ff;
   div_stage_type         dv_ff [DIV_STAGES];
   div_stage_type         dv_in [DIV_STAGES];

   logic              out_valid_ff;
   logic              out_lane_ff, out_lane_in;
   logic [CHAN_W-1:0] out_sat_ff, out_sat_in;
   logic [CHAN_W-1:0] out_bright_ff;

   logic advance;

   // The pipeline moves whenever the output register is empty or being drained.
   assign advance        = !out_valid_ff || rsp_chan.ready;
   assign req_chan.ready = advance;
   assign csr_chan.ready = 1'b1;

   // Threshold registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         sat_low_ff  <= SAT_LOW_RESET;
         sat_high_ff <= SAT_HIGH_RESET;
         val_low_ff  <= VAL_LOW_RESET;
         val_high_ff <= VAL_HIGH_RESET;
      end else if (csr_chan.valid) begin
         unique case (csr_index_type'(csr_chan.index))
            CSR_SAT_LOW:  sat_low_ff  <= csr_chan.data;
            CSR_SAT_HIGH: sat_high_ff <= csr_chan.data;
            CSR_VAL_LOW:  val_low_ff  <= csr_chan.data;
            CSR_VAL_HIGH: val_high_ff <= csr_chan.data;
         endcase
      end
   end

   // Stage 1: maximum and minimum of the three channels.
   always_comb begin
      s1_mx_in = req_chan.chan_first;
      s1_mn_in = req_chan.chan_first;
      if (req_chan.chan_second > s1_mx_in) s1_mx_in = req_chan.chan_second;
      if (req_chan.chan_third  > s1_mx_in) s1_mx_in = req_chan.chan_third;
      if (req_chan.chan_second < s1_mn_in) s1_mn_in = req_chan.chan_second;
      if (req_chan.chan_third  < s1_mn_in) s1_mn_in = req_chan.chan_third;
   end

   // Stage 2: numerator 255*(mx-mn) and the lightness-dependent divisor.
   always_comb begin
      logic [CHAN_W-1:0] diff;
      logic [CHAN_W:0]   total;
      diff     = s1_mx_ff - s1_mn_ff;
      total    = {1'b0, s1_mx_ff} + {1'b0, s1_mn_ff};
      s2_in    = '0;
      s2_in.grey = (s1_mx_ff == s1_mn_ff);
      s2_in.mx   = s1_mx_ff;
      s2_in.rem  = {diff, {CHAN_W{1'b0}}} - NUM_W'(diff);
      if (total < (CHAN_W+1)'(CHAN_MAX)) begin
         s2_in.den = total[CHAN_W-1:0];
      end else begin
         s2_in.den = CHAN_W'(((CHAN_W+1)'(2) * (CHAN_W+1)'(CHAN_MAX)) - total);
      end
   end

   // Divider stages: each resolves two quotient bits, most significant first.
   always_comb begin
      for (int unsigned i = 0; i < DIV_STAGES; i++) begin
         dv_in[i] = div_two((i == 0) ? s2_ff : dv_ff[(i == 0) ? 0 : i-1],
                            CHAN_W - 1 - DIV_BITS_PER_STAGE * i);
      end
   end

   // Output stage: round half to even, then the two window checks.
   always_comb begin
      div_stage_type     last;
      logic [NUM_W:0]    rem2;
      logic              round_up;
      last     = dv_ff[DIV_STAGES-1];
      rem2     = {last.rem, 1'b0};
      round_up = (rem2 > (NUM_W+1)'(last.den)) ||
                 ((rem2 == (NUM_W+1)'(last.den)) && last.quo[0]);
      if (last.grey) begin
         out_sat_in = '0;
      end else if (round_up && (last.quo != CHAN_MAX)) begin
         out_sat_in = last.quo + CHAN_W'(1);
      end else begin
         out_sat_in = last.quo;
      end
      out_lane_in = (out_sat_in > sat_low_ff) && (out_sat_in <= sat_high_ff) &&
                    (last.mx > val_low_ff) && (last.mx <= val_high_ff);
   end

   // Valid bits travel with the data.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         dv_valid_ff  <= '0;
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff  <= req_chan.valid;
         s2_valid_ff  <= s1_valid_ff;
         dv_valid_ff  <= {dv_valid_ff[DIV_STAGES-2:0], s2_valid_ff};
         out_valid_ff <= dv_valid_ff[DIV_STAGES-1];
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (advance) begin
         s1_mx_ff      <= s1_mx_in;
         s1_mn_ff      <= s1_mn_in;
         s2_ff         <= s2_in;
         for (int unsigned i = 0; i < DIV_STAGES; i++) begin
            dv_ff[i] <= dv_in[i];
         end
         out_lane_ff   <= out_lane_in;
         out_sat_ff    <= out_sat_in;
         out_bright_ff <= dv_ff[DIV_STAGES-1].mx;
      end
   end

   assign rsp_chan.valid      = out_valid_ff;
   assign rsp_chan.lane_bit   = out_lane_ff;
   assign rsp_chan.saturation = out_sat_ff;
   assign rsp_chan.brightness = out_bright_ff;

endmodule

/* hw/rtl/svct_checker.sv */
// Port-level assertions for the color threshold block and their bind.
module svct_checker
   import svct_pkg::*;
(
   input logic              clock,
   input logic              reset,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic              rsp_lane_bit,
   input logic [CHAN_W-1:0] rsp_saturation,
   input logic [CHAN_W-1:0] rsp_brightness,
   input logic              csr_ready
);

   // A stalled result item holds its value.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_saturation) &&
      $stable(rsp_brightness) && $stable(rsp_lane_bit))
      else $error("stalled result item changed");

   // The pipeline is empty right after reset.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // A lane hit needs saturation and value strictly above their lower bounds.
   a_lane_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_lane_bit |-> rsp_saturation != '0 && rsp_brightness != '0)
      else $error("lane hit with zero saturation or value");

   // A black pixel is grey, so nonzero saturation needs nonzero value.
   a_sat_needs_value: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_saturation != '0 |-> rsp_brightness != '0)
      else $error("saturation on a black pixel");

   // Configuration writes are never stalled.
   a_csr_ready: assert property (@(posedge clock) disable iff (reset)
      csr_ready)
      else $error("configuration port stalled");

endmodule

bind saturation_value_color_threshold svct_checker u_svct_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_chan.valid),
   .rsp_ready      (rsp_chan.ready),
   .rsp_lane_bit   (rsp_chan.lane_bit),
   .rsp_saturation (rsp_chan.saturation),
   .rsp_brightness (rsp_chan.brightness),
   .csr_ready      (csr_chan.ready)
);
